// ===== src/triangle_normal_direction_test_top_macros.svh =====
// Assertion macros shared by the triangle normal direction test RTL.
`ifndef TRIANGLE_NORMAL_DIRECTION_TEST_TOP_MACROS_SVH
`define TRIANGLE_NORMAL_DIRECTION_TEST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TNDT_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TNDT_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tndt_pkg.sv =====
// Package: widths, types and register indexes of the triangle normal direction test.
`timescale 1ns / 1ps
`default_nettype none
package tndt_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIR_W      = 16;
  localparam int COS_W      = 16;
  localparam int MIN_W      = 32;

  // Edge, cross product and normal widths
  localparam int EW  = COORD_BITS + 1;
  localparam int PW  = 2 * EW;
  localparam int NW  = PW + 1;
  localparam int NMW = NW - 1;
  localparam int SQW = 2 * NMW;
  localparam int NNW = SQW + 2;

  // Dot product with the direction
  localparam int TW  = NW + DIR_W;
  localparam int PSW = TW + 2;
  localparam int PMW = PSW - 1;

  // Split operands for the wide squares
  localparam int PLW  = (PMW + 1) / 2;
  localparam int PHW  = PMW - PLW;
  localparam int PSQW = 2 * PMW;
  localparam int CMW  = COS_W;
  localparam int CSW  = 2 * CMW;
  localparam int NLW  = (NNW + 1) / 2;
  localparam int NHW  = NNW - NLW;
  localparam int RHW  = CSW + NNW;
  localparam int CMPW = (PSQW > RHW) ? PSQW : RHW;

  localparam int HHW  = 2 * PHW;
  localparam int HLW  = PHW + PLW;
  localparam int LLW  = 2 * PLW;
  localparam int RCHW = CSW + NHW;
  localparam int RCLW = CSW + NLW;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DIR_X     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_DIR_Y     = cfg_idx_t'(1);
  localparam cfg_idx_t REG_DIR_Z     = cfg_idx_t'(2);
  localparam cfg_idx_t REG_COS_TH    = cfg_idx_t'(3);
  localparam cfg_idx_t REG_MIN_NORM  = cfg_idx_t'(4);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EW-1:0]         evec_t;
  typedef logic signed [PW-1:0]         xprod_t;
  typedef logic signed [NW-1:0]         nrm_t;
  typedef logic signed [DIR_W-1:0]      dir_t;
  typedef logic signed [COS_W-1:0]      cos_t;
  typedef logic [MIN_W-1:0]             minsq_t;
  typedef logic [NNW-1:0]               nnsq_t;
  typedef logic signed [PSW-1:0]        dotp_t;

  typedef struct packed {
    coord_t a_x, a_y, a_z;
    coord_t b_x, b_y, b_z;
    coord_t c_x, c_y, c_z;
  } trg_t;

  typedef struct packed {
    evec_t x, y, z;
  } evec3_t;

  typedef struct packed {
    nrm_t x, y, z;
  } normal_t;

  typedef struct packed {
    nnsq_t nn;
    dotp_t p;
  } proj_t;

  typedef struct packed {
    dir_t   dir_x;
    dir_t   dir_y;
    dir_t   dir_z;
    cos_t   cos_th;
    minsq_t min_norm_sq;
  } cfg_t;

  typedef struct packed {
    logic keep;
    logic degenerate;
  } res_t;

endpackage
`default_nettype wire

// ===== src/tndt_if.sv =====
// Interfaces: triangle input channel and test result channel.
`timescale 1ns / 1ps
`default_nettype none
interface tndt_in_if;
  import tndt_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_x, a_y, a_z;
  coord_t b_x, b_y, b_z;
  coord_t c_x, c_y, c_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

interface tndt_out_if;
  logic valid;
  logic ready;
  logic keep;
  logic degenerate;

  modport source (output valid, keep, degenerate, input ready);
  modport sink (input valid, keep, degenerate, output ready);
endinterface
`default_nettype wire

// ===== src/tndt_cross.sv =====
// Edge vectors and cross product: three pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module tndt_cross (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire tndt_pkg::trg_t    trg,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output tndt_pkg::normal_t      nrm
);
  import tndt_pkg::*;

  localparam int NSTG = 3;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  evec3_t          e1_r, e2_r;
  xprod_t          pr_r [6];
  normal_t         nrm_r;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || dn_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[NSTG-1];
  assign nrm      = nrm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1_r.x <= EW'(trg.a_x) - EW'(trg.b_x);
      e1_r.y <= EW'(trg.a_y) - EW'(trg.b_y);
      e1_r.z <= EW'(trg.a_z) - EW'(trg.b_z);
      e2_r.x <= EW'(trg.c_x) - EW'(trg.b_x);
      e2_r.y <= EW'(trg.c_y) - EW'(trg.b_y);
      e2_r.z <= EW'(trg.c_z) - EW'(trg.b_z);
    end
    if (en[1]) begin
      pr_r[0] <= PW'(e2_r.y) * PW'(e1_r.z);
      pr_r[1] <= PW'(e2_r.z) * PW'(e1_r.y);
      pr_r[2] <= PW'(e2_r.z) * PW'(e1_r.x);
      pr_r[3] <= PW'(e2_r.x) * PW'(e1_r.z);
      pr_r[4] <= PW'(e2_r.x) * PW'(e1_r.y);
      pr_r[5] <= PW'(e2_r.y) * PW'(e1_r.x);
    end
    if (en[2]) begin
      nrm_r.x <= NW'(pr_r[0]) - NW'(pr_r[1]);
      nrm_r.y <= NW'(pr_r[2]) - NW'(pr_r[3]);
      nrm_r.z <= NW'(pr_r[4]) - NW'(pr_r[5]);
    end
  end

endmodule
`default_nettype wire

// ===== src/tndt_proj.sv =====
// Squared normal length and dot product with the direction: two stages.
`timescale 1ns / 1ps
`default_nettype none
module tndt_proj (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tndt_pkg::cfg_t    cfg,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire tndt_pkg::normal_t nrm,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output tndt_pkg::proj_t        prj
);
  import tndt_pkg::*;

  localparam int NSTG = 2;

  logic [NSTG-1:0]         vld_r;
  logic [NSTG-1:0]         en;
  logic [NMW-1:0]          mx, my, mz;
  logic [SQW-1:0]          sq_r [3];
  logic signed [TW-1:0]    dt_r [3];
  proj_t                   prj_r;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || dn_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[NSTG-1];
  assign prj      = prj_r;

  // magnitudes never reach the most negative code of NW bits
  assign mx = nrm.x[NW-1] ? NMW'(-nrm.x) : NMW'(nrm.x);
  assign my = nrm.y[NW-1] ? NMW'(-nrm.y) : NMW'(nrm.y);
  assign mz = nrm.z[NW-1] ? NMW'(-nrm.z) : NMW'(nrm.z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_r[0] <= SQW'(mx) * SQW'(mx);
      sq_r[1] <= SQW'(my) * SQW'(my);
      sq_r[2] <= SQW'(mz) * SQW'(mz);
      dt_r[0] <= TW'(nrm.x) * TW'(cfg.dir_x);
      dt_r[1] <= TW'(nrm.y) * TW'(cfg.dir_y);
      dt_r[2] <= TW'(nrm.z) * TW'(cfg.dir_z);
    end
    if (en[1]) begin
      prj_r.nn <= NNW'(sq_r[0]) + NNW'(sq_r[1]) + NNW'(sq_r[2]);
      prj_r.p  <= PSW'(dt_r[0]) + PSW'(dt_r[1]) + PSW'(dt_r[2]);
    end
  end

endmodule
`default_nettype wire

// ===== src/tndt_cmp.sv =====
// Degenerate check and angle decision by squares: four stages, last is the output register.
`timescale 1ns / 1ps
`default_nettype none
module tndt_cmp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tndt_pkg::cfg_t    cfg,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire tndt_pkg::proj_t   prj,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output tndt_pkg::res_t         res
);
  import tndt_pkg::*;

  localparam int NSTG = 4;

  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  en;

  logic [CMW-1:0]   cos_mag;
  logic [CSW-1:0]   cos_sq_r;

  logic             degen_f_r, pneg_f_r;
  logic [PMW-1:0]   pm_f_r;
  nnsq_t            nn_f_r;

  logic             degen_g_r, pneg_g_r;
  logic [HHW-1:0]   hh_r;
  logic [HLW-1:0]   hl_r;
  logic [LLW-1:0]   ll_r;
  logic [RCHW-1:0]  rch_r;
  logic [RCLW-1:0]  rcl_r;

  logic             degen_h_r, pneg_h_r;
  logic [CMPW-1:0]  psq_r, rhs_r;

  res_t             res_r;
  logic             cos_le0, cos_ge0;
  logic             keep_nxt;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || dn_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[NSTG-1];
  assign res      = res_r;

  // cos^2 is registered; user must change config only while pipe is empty; not enforced
  assign cos_mag = cfg.cos_th[COS_W-1] ? CMW'(-cfg.cos_th) : CMW'(cfg.cos_th);

  always_ff @(posedge clk) begin
    cos_sq_r <= CSW'(cos_mag) * CSW'(cos_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign cos_le0 = cfg.cos_th[COS_W-1] || (cfg.cos_th == '0);
  assign cos_ge0 = !cfg.cos_th[COS_W-1];

  // degenerate check first, then sign test, then p^2 against cos^2 * |n|^2
  always_comb begin
    if (degen_h_r) begin
      keep_nxt = 1'b0;
    end else if (!pneg_h_r && cos_le0) begin
      keep_nxt = 1'b1;
    end else if (pneg_h_r && cos_ge0) begin
      keep_nxt = 1'b0;
    end else if (!pneg_h_r) begin
      keep_nxt = (psq_r >= rhs_r);
    end else begin
      keep_nxt = (psq_r <= rhs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      degen_f_r <= (prj.nn < NNW'(cfg.min_norm_sq));
      pneg_f_r  <= prj.p[PSW-1];
      pm_f_r    <= prj.p[PSW-1] ? PMW'(-prj.p) : PMW'(prj.p);
      nn_f_r    <= prj.nn;
    end
    if (en[1]) begin
      degen_g_r <= degen_f_r;
      pneg_g_r  <= pneg_f_r;
      hh_r      <= HHW'(pm_f_r[PMW-1:PLW]) * HHW'(pm_f_r[PMW-1:PLW]);
      hl_r      <= HLW'(pm_f_r[PMW-1:PLW]) * HLW'(pm_f_r[PLW-1:0]);
      ll_r      <= LLW'(pm_f_r[PLW-1:0]) * LLW'(pm_f_r[PLW-1:0]);
      rch_r     <= RCHW'(cos_sq_r) * RCHW'(nn_f_r[NNW-1:NLW]);
      rcl_r     <= RCLW'(cos_sq_r) * RCLW'(nn_f_r[NLW-1:0]);
    end
    if (en[2]) begin
      degen_h_r <= degen_g_r;
      pneg_h_r  <= pneg_g_r;
      psq_r     <= (CMPW'(hh_r) << (2 * PLW)) + (CMPW'(hl_r) << (PLW + 1)) + CMPW'(ll_r);
      rhs_r     <= (CMPW'(rch_r) << NLW) + CMPW'(rcl_r);
    end
    if (en[3]) begin
      res_r.keep       <= keep_nxt;
      res_r.degenerate <= degen_h_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/triangle_normal_direction_test_top.sv =====
// Top level: configuration registers and the three pipeline sections.
//
// One triangle (vertices a, b, c; b is the pivot) enters on in_tri per
// transaction; one result (keep, degenerate) leaves on out_res per triangle,
// in input order. Configuration is written through cfg_we / cfg_idx /
// cfg_wdata; the user must do so only while no triangle is in flight, as
// the block itself does not enforce it. Unknown indexes are ignored.
// The pipeline has 3 cross product stages, 2 projection stages and 4 compare
// stages, the last being the output register.
// Throughput: one triangle per cycle while out_res.ready is high. Every
// stage loads when it is empty or its content moves on, so bubbles close up
// and out_res.ready high always gives in_tri.ready high.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// direction (0, 32767, 0), cosine threshold 32643 and minimum |n|^2 of 1.
// When the receiver stalls, the output register holds its result and the
// stages behind it fill up; in_tri.ready drops once all nine are full.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_normal_direction_test_top_macros.svh"
module triangle_normal_direction_test_top (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire tndt_pkg::cfg_idx_t     cfg_idx,
  input  wire logic [tndt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tndt_in_if.sink                     in_tri,
  tndt_out_if.source                  out_res
);
  import tndt_pkg::*;

  dir_t    dir_x_r, dir_y_r, dir_z_r;
  cos_t    cos_r;
  minsq_t  min_norm_sq_r;
  cfg_t    cfg;

  trg_t    trg;
  logic    x_valid, x_ready;
  normal_t nrm;
  logic    p_valid, p_ready;
  proj_t   prj;
  res_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r       <= dir_t'(0);
      dir_y_r       <= dir_t'(32767);
      dir_z_r       <= dir_t'(0);
      cos_r         <= cos_t'(32643);
      min_norm_sq_r <= minsq_t'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIR_X:    dir_x_r       <= cfg_wdata[DIR_W-1:0];
        REG_DIR_Y:    dir_y_r       <= cfg_wdata[DIR_W-1:0];
        REG_DIR_Z:    dir_z_r       <= cfg_wdata[DIR_W-1:0];
        REG_COS_TH:   cos_r         <= cfg_wdata[COS_W-1:0];
        REG_MIN_NORM: min_norm_sq_r <= cfg_wdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.dir_x       = dir_x_r;
  assign cfg.dir_y       = dir_y_r;
  assign cfg.dir_z       = dir_z_r;
  assign cfg.cos_th      = cos_r;
  assign cfg.min_norm_sq = min_norm_sq_r;

  assign trg.a_x = in_tri.a_x;
  assign trg.a_y = in_tri.a_y;
  assign trg.a_z = in_tri.a_z;
  assign trg.b_x = in_tri.b_x;
  assign trg.b_y = in_tri.b_y;
  assign trg.b_z = in_tri.b_z;
  assign trg.c_x = in_tri.c_x;
  assign trg.c_y = in_tri.c_y;
  assign trg.c_z = in_tri.c_z;

  tndt_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tri.valid),
    .up_ready (in_tri.ready),
    .trg      (trg),
    .dn_valid (x_valid),
    .dn_ready (x_ready),
    .nrm      (nrm)
  );

  tndt_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (x_valid),
    .up_ready (x_ready),
    .nrm      (nrm),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .prj      (prj)
  );

  tndt_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .prj      (prj),
    .dn_valid (out_res.valid),
    .dn_ready (out_res.ready),
    .res      (res)
  );

  assign out_res.keep       = res.keep;
  assign out_res.degenerate = res.degenerate;

  `TNDT_AST_IMP(a_degen_never_kept, out_res.valid && out_res.degenerate, !out_res.keep, "degenerate triangle marked keep")
  `TNDT_AST_IMP(a_full_rate, out_res.ready, in_tri.ready, "input stalled while output drains")
  `TNDT_AST_IMP(a_zero_min_no_degen, out_res.valid && (min_norm_sq_r == '0), !out_res.degenerate, "degenerate flagged with zero minimum")

endmodule
`default_nettype wire
